FILE: sv/euler_to_rotation_matrix_macros.svh
// Assertion shorthands for the rotation-matrix RTL.
`ifndef EULER_TO_ROTATION_MATRIX_MACROS_SVH
`define EULER_TO_ROTATION_MATRIX_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define E2R_ASSERT_IMPLY(name, clk, rst, cond, conseq, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define E2R_ASSERT_NEXT(name, clk, rst, cond, conseq, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error(msg);

`endif

FILE: sv/e2r_pkg.sv
package e2r_pkg;

   localparam int ANGLE_BITS       = 16;
   localparam int FRACTION_BITS    = 14;
   localparam int SINE_TABLE_DEPTH = 256;

   localparam int FIELD_W = 16;
   localparam int REM_W   = ANGLE_BITS - 2;
   localparam int TAB_W   = FRACTION_BITS + 1;
   localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int POS_W   = ANGLE_BITS - 1 + IDX_W;
   localparam int VAL_W   = FRACTION_BITS + 2;
   localparam int PROD_W  = 2 * VAL_W + 1;
   localparam int RND_W   = PROD_W - FRACTION_BITS;
   localparam int IP_W    = TAB_W + REM_W + 1;

   // register stages from input to output
   localparam int NSTAGE = 7;

   localparam logic [63:0] HALF_PI_Q60  = 64'h1921FB54442D1847;
   localparam logic [63:0] QUARTER_STEP = HALF_PI_Q60 / SINE_TABLE_DEPTH;
   localparam logic [63:0] QUARTER_REST = HALF_PI_Q60 % SINE_TABLE_DEPTH;

   typedef logic [ANGLE_BITS-1:0]             angle_type;
   typedef logic [TAB_W-1:0]                  tab_entry_type;
   typedef logic [SINE_TABLE_DEPTH:0][TAB_W-1:0] sine_tab_type;
   typedef logic [IDX_W-1:0]                  tab_idx_type;
   typedef logic signed [VAL_W-1:0]           val_type;
   typedef logic signed [PROD_W-1:0]          prod_type;
   typedef logic signed [RND_W-1:0]           rnd_type;

   // Load strobes of the three sine/cosine stages.
   typedef struct packed {
      logic load1;
      logic load2;
      logic load3;
   } stage_load_type;

   localparam logic [ANGLE_BITS-2:0] QUARTER = {1'b1, {REM_W{1'b0}}};
   localparam val_type ONE_FX = val_type'(64'd1 << FRACTION_BITS);

   // floor(a * b / 2^60), used only while building the table
   function automatic logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[123:60];
   endfunction

   // Taylor series of sine in Q60, each term truncated
   function automatic logic [63:0] sin_q60(logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      x2   = mul_q60(x, x);
      term = x;
      sum  = x;
      term = mul_q60(term, x2) / 64'd6;    sum = sum - term;
      term = mul_q60(term, x2) / 64'd20;   sum = sum + term;
      term = mul_q60(term, x2) / 64'd42;   sum = sum - term;
      term = mul_q60(term, x2) / 64'd72;   sum = sum + term;
      term = mul_q60(term, x2) / 64'd110;  sum = sum - term;
      term = mul_q60(term, x2) / 64'd156;  sum = sum + term;
      term = mul_q60(term, x2) / 64'd210;  sum = sum - term;
      term = mul_q60(term, x2) / 64'd272;  sum = sum + term;
      term = mul_q60(term, x2) / 64'd342;  sum = sum - term;
      term = mul_q60(term, x2) / 64'd420;  sum = sum + term;
      term = mul_q60(term, x2) / 64'd506;  sum = sum - term;
      term = mul_q60(term, x2) / 64'd600;  sum = sum + term;
      term = mul_q60(term, x2) / 64'd702;  sum = sum - term;
      term = mul_q60(term, x2) / 64'd812;  sum = sum + term;
      term = mul_q60(term, x2) / 64'd930;  sum = sum - term;
      term = mul_q60(term, x2) / 64'd1056; sum = sum + term;
      return sum;
   endfunction

   function automatic sine_tab_type build_sine_tab();
      sine_tab_type t;
      logic [63:0]  x;
      logic [63:0]  s;
      int           i;
      for (i = 0; i <= SINE_TABLE_DEPTH; i++) begin
         x = QUARTER_STEP * 64'(i) + (QUARTER_REST * 64'(i)) / SINE_TABLE_DEPTH;
         s = sin_q60(x);
         t[i] = TAB_W'((s + (64'd1 << (59 - FRACTION_BITS))) >> (60 - FRACTION_BITS));
      end
      return t;
   endfunction

   // Quarter-wave sine table, entry DEPTH is exactly one
   localparam sine_tab_type SINE_TAB = build_sine_tab();

   function automatic prod_type mul_fx(val_type a, val_type b);
      logic signed [2*VAL_W-1:0] p;
      p = a * b;
      return PROD_W'(p);
   endfunction

   // Round half up, dropping FRACTION_BITS
   function automatic rnd_type round_fx(prod_type v);
      prod_type half;
      prod_type w;
      half = '0;
      half[FRACTION_BITS-1] = 1'b1;
      w = v + half;
      return RND_W'(w >>> FRACTION_BITS);
   endfunction

   function automatic val_type sat_fx(rnd_type v);
      rnd_type hi;
      rnd_type lo;
      hi = RND_W'(ONE_FX);
      lo = -hi;
      if (v > hi) begin
         return ONE_FX;
      end else if (v < lo) begin
         return -ONE_FX;
      end
      return VAL_W'(v);
   endfunction

endpackage

FILE: sv/e2r_channels.sv
interface e2r_req_if import e2r_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [FIELD_W-1:0] roll_angle;
   logic [FIELD_W-1:0] pitch_angle;
   logic [FIELD_W-1:0] yaw_angle;

   modport source (output valid, output roll_angle, output pitch_angle, output yaw_angle,
                   input ready);
   modport sink   (input valid, input roll_angle, input pitch_angle, input yaw_angle,
                   output ready);
endinterface

interface e2r_rsp_if import e2r_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [FIELD_W-1:0] elem_00;
   logic signed [FIELD_W-1:0] elem_01;
   logic signed [FIELD_W-1:0] elem_02;
   logic signed [FIELD_W-1:0] elem_10;
   logic signed [FIELD_W-1:0] elem_11;
   logic signed [FIELD_W-1:0] elem_12;
   logic signed [FIELD_W-1:0] elem_20;
   logic signed [FIELD_W-1:0] elem_21;
   logic signed [FIELD_W-1:0] elem_22;

   modport source (output valid, output elem_00, output elem_01, output elem_02,
                   output elem_10, output elem_11, output elem_12,
                   output elem_20, output elem_21, output elem_22, input ready);
   modport sink   (input valid, input elem_00, input elem_01, input elem_02,
                   input elem_10, input elem_11, input elem_12,
                   input elem_20, input elem_21, input elem_22, output ready);
endinterface

FILE: sv/e2r_sincos.sv
module e2r_sincos import e2r_pkg::*; (
   input  logic           clock,
   input  stage_load_type load,
   input  angle_type      angle,
   output val_type        sine
);

   // stage 1: fold into the first quadrant, split table position
   logic [1:0]            quad;
   logic [ANGLE_BITS-2:0] fold;
   logic [POS_W-1:0]      pos;
   tab_idx_type           idx_in;
   tab_idx_type           idx_ff;
   logic [REM_W-1:0]      rem_in;
   logic [REM_W-1:0]      rem1_ff;
   logic                  neg1_ff;

   // stage 2: table reads
   tab_idx_type           nxt;
   tab_entry_type         base_ff;
   tab_entry_type         next_ff;
   logic [REM_W-1:0]      rem2_ff;
   logic                  neg2_ff;

   // stage 3: interpolate and sign
   tab_entry_type         diff;
   logic [IP_W-1:0]       interp;
   tab_entry_type         mag;
   val_type               sine_in;
   val_type               sine_ff;

   always_comb begin
      quad   = angle[ANGLE_BITS-1 -: 2];
      fold   = quad[0] ? QUARTER - {1'b0, angle[REM_W-1:0]} : {1'b0, angle[REM_W-1:0]};
      pos    = POS_W'(fold) * POS_W'(SINE_TABLE_DEPTH);
      idx_in = IDX_W'(pos >> REM_W);
      rem_in = pos[REM_W-1:0];
   end

   // the last entry has no successor; its remainder is always zero
   assign nxt = (idx_ff == IDX_W'(SINE_TABLE_DEPTH)) ? idx_ff : idx_ff + IDX_W'(1);

   always_comb begin
      diff    = next_ff - base_ff;
      interp  = IP_W'(diff) * IP_W'(rem2_ff) + (IP_W'(1) << (REM_W - 1));
      mag     = base_ff + TAB_W'(interp >> REM_W);
      sine_in = neg2_ff ? -val_type'({1'b0, mag}) : val_type'({1'b0, mag});
   end

   always_ff @(posedge clock) begin
      if (load.load1) begin
         idx_ff  <= idx_in;
         rem1_ff <= rem_in;
         neg1_ff <= quad[1];
      end
      if (load.load2) begin
         base_ff <= SINE_TAB[idx_ff];
         next_ff <= SINE_TAB[nxt];
         rem2_ff <= rem1_ff;
         neg2_ff <= neg1_ff;
      end
      if (load.load3) begin
         sine_ff <= sine_in;
      end
   end

   assign sine = sine_ff;

endmodule

FILE: sv/euler_to_rotation_matrix.sv
// ZYX Euler angles to rotation matrix. Each item carries roll, pitch and yaw as
// unsigned binary angles (2^ANGLE_BITS units per turn) and returns the nine
// entries of Rz(yaw) * Ry(pitch) * Rx(roll) as signed fixed point with
// FRACTION_BITS fractional bits, rounded half up and clamped to +/-1. Sine and
// cosine come from a quarter-wave table with linear interpolation; the table
// is a constant built at elaboration, so there is no start-up pass after reset.
// The datapath is a seven-stage pipeline: three stages for the table lookup
// and interpolation, then two multiply/round passes. One item is accepted
// every cycle; each stage holds on its own, so a stalled output blocks input
// only once every stage is full.
module euler_to_rotation_matrix import e2r_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   e2r_req_if.sink       req_ch,
   e2r_rsp_if.source     rsp_ch
);

`include "euler_to_rotation_matrix_macros.svh"

   logic [NSTAGE-1:0] valid_ff;
   logic [NSTAGE-1:0] stage_ready;
   stage_load_type    load;

   angle_type roll;
   angle_type pitch;
   angle_type yaw;
   val_type   sr;
   val_type   cr;
   val_type   sp;
   val_type   cp;
   val_type   sy;
   val_type   cy;

   // stage 3: first products
   prod_type p_cpcy_ff;
   prod_type p_cpsy_ff;
   prod_type p_srcp_ff;
   prod_type p_crcp_ff;
   prod_type p_spcy_ff;
   prod_type p_spsy_ff;
   val_type  sr3_ff;
   val_type  cr3_ff;
   val_type  sy3_ff;
   val_type  cy3_ff;
   val_type  sp3_ff;

   // stage 4: rounded products
   val_type spcy_ff;
   val_type spsy_ff;
   val_type e00_4_ff;
   val_type e10_4_ff;
   val_type e20_4_ff;
   val_type e21_4_ff;
   val_type e22_4_ff;
   val_type sr4_ff;
   val_type cr4_ff;
   val_type sy4_ff;
   val_type cy4_ff;

   // stage 5: second products
   prod_type p_a_ff;
   prod_type p_b_ff;
   prod_type p_c_ff;
   prod_type p_d_ff;
   prod_type p_e_ff;
   prod_type p_f_ff;
   prod_type p_g_ff;
   prod_type p_h_ff;
   val_type  e00_5_ff;
   val_type  e10_5_ff;
   val_type  e20_5_ff;
   val_type  e21_5_ff;
   val_type  e22_5_ff;

   // stage 6: output register
   val_type e00_ff;
   val_type e01_ff;
   val_type e02_ff;
   val_type e10_ff;
   val_type e11_ff;
   val_type e12_ff;
   val_type e20_ff;
   val_type e21_ff;
   val_type e22_ff;

   // a stage takes new data when it is empty or its successor moves
   always_comb begin
      stage_ready[NSTAGE-1] = !valid_ff[NSTAGE-1] || rsp_ch.ready;
      for (int k = NSTAGE - 2; k >= 0; k--) begin
         stage_ready[k] = !valid_ff[k] || stage_ready[k+1];
      end
   end

   assign load.load1 = stage_ready[0];
   assign load.load2 = stage_ready[1];
   assign load.load3 = stage_ready[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (stage_ready[0]) begin
            valid_ff[0] <= req_ch.valid;
         end
         for (int k = 1; k < NSTAGE; k++) begin
            if (stage_ready[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   assign roll  = angle_type'(req_ch.roll_angle);
   assign pitch = angle_type'(req_ch.pitch_angle);
   assign yaw   = angle_type'(req_ch.yaw_angle);

   e2r_sincos u_sin_roll  (.clock(clock), .load(load), .angle(roll), .sine(sr));
   e2r_sincos u_cos_roll  (.clock(clock), .load(load),
                           .angle(roll + angle_type'(QUARTER)), .sine(cr));
   e2r_sincos u_sin_pitch (.clock(clock), .load(load), .angle(pitch), .sine(sp));
   e2r_sincos u_cos_pitch (.clock(clock), .load(load),
                           .angle(pitch + angle_type'(QUARTER)), .sine(cp));
   e2r_sincos u_sin_yaw   (.clock(clock), .load(load), .angle(yaw), .sine(sy));
   e2r_sincos u_cos_yaw   (.clock(clock), .load(load),
                           .angle(yaw + angle_type'(QUARTER)), .sine(cy));

   always_ff @(posedge clock) begin
      if (stage_ready[3]) begin
         p_cpcy_ff <= mul_fx(cp, cy);
         p_cpsy_ff <= mul_fx(cp, sy);
         p_srcp_ff <= mul_fx(sr, cp);
         p_crcp_ff <= mul_fx(cr, cp);
         p_spcy_ff <= mul_fx(sp, cy);
         p_spsy_ff <= mul_fx(sp, sy);
         sr3_ff    <= sr;
         cr3_ff    <= cr;
         sy3_ff    <= sy;
         cy3_ff    <= cy;
         sp3_ff    <= sp;
      end
      if (stage_ready[4]) begin
         // inner products keep full range, no clamp
         spcy_ff  <= VAL_W'(round_fx(p_spcy_ff));
         spsy_ff  <= VAL_W'(round_fx(p_spsy_ff));
         e00_4_ff <= sat_fx(round_fx(p_cpcy_ff));
         e10_4_ff <= sat_fx(round_fx(p_cpsy_ff));
         e20_4_ff <= -sp3_ff;
         e21_4_ff <= sat_fx(round_fx(p_srcp_ff));
         e22_4_ff <= sat_fx(round_fx(p_crcp_ff));
         sr4_ff   <= sr3_ff;
         cr4_ff   <= cr3_ff;
         sy4_ff   <= sy3_ff;
         cy4_ff   <= cy3_ff;
      end
      if (stage_ready[5]) begin
         p_a_ff   <= mul_fx(sr4_ff, spcy_ff);
         p_b_ff   <= mul_fx(cr4_ff, sy4_ff);
         p_c_ff   <= mul_fx(sr4_ff, sy4_ff);
         p_d_ff   <= mul_fx(cr4_ff, spcy_ff);
         p_e_ff   <= mul_fx(cr4_ff, cy4_ff);
         p_f_ff   <= mul_fx(sr4_ff, spsy_ff);
         p_g_ff   <= mul_fx(cr4_ff, spsy_ff);
         p_h_ff   <= mul_fx(sr4_ff, cy4_ff);
         e00_5_ff <= e00_4_ff;
         e10_5_ff <= e10_4_ff;
         e20_5_ff <= e20_4_ff;
         e21_5_ff <= e21_4_ff;
         e22_5_ff <= e22_4_ff;
      end
      if (stage_ready[6]) begin
         e00_ff <= e00_5_ff;
         e01_ff <= sat_fx(round_fx(p_a_ff - p_b_ff));
         e02_ff <= sat_fx(round_fx(p_c_ff + p_d_ff));
         e10_ff <= e10_5_ff;
         e11_ff <= sat_fx(round_fx(p_e_ff + p_f_ff));
         e12_ff <= sat_fx(round_fx(p_g_ff - p_h_ff));
         e20_ff <= e20_5_ff;
         e21_ff <= e21_5_ff;
         e22_ff <= e22_5_ff;
      end
   end

   assign req_ch.ready   = stage_ready[0];
   assign rsp_ch.valid   = valid_ff[NSTAGE-1];
   assign rsp_ch.elem_00 = FIELD_W'(e00_ff);
   assign rsp_ch.elem_01 = FIELD_W'(e01_ff);
   assign rsp_ch.elem_02 = FIELD_W'(e02_ff);
   assign rsp_ch.elem_10 = FIELD_W'(e10_ff);
   assign rsp_ch.elem_11 = FIELD_W'(e11_ff);
   assign rsp_ch.elem_12 = FIELD_W'(e12_ff);
   assign rsp_ch.elem_20 = FIELD_W'(e20_ff);
   assign rsp_ch.elem_21 = FIELD_W'(e21_ff);
   assign rsp_ch.elem_22 = FIELD_W'(e22_ff);

   `E2R_ASSERT_NEXT(a_accept_enters, clock, reset, req_ch.valid && req_ch.ready, valid_ff[0], "accepted item missing from first stage")
   `E2R_ASSERT_NEXT(a_stalled_stage_holds, clock, reset, valid_ff[3] && !stage_ready[3], valid_ff[3], "stalled stage dropped its item")
   `E2R_ASSERT_IMPLY(a_mixed_in_range, clock, reset, valid_ff[NSTAGE-1], (e01_ff <= ONE_FX) && (e01_ff >= -ONE_FX) && (e12_ff <= ONE_FX) && (e12_ff >= -ONE_FX), "matrix entry beyond unit range")

endmodule

FILE: test/euler_to_rotation_matrix_test.sv
module euler_to_rotation_matrix_test import e2r_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int    RANDOM_ITEMS = 1200;
   localparam int    CYCLE_LIMIT  = 200000;
   localparam int    HOLD_CYCLES  = 120;
   localparam int    IDLE_PERCENT = 14;
   localparam int    MAX_REPORTS  = 10;
   localparam longint QTR_TURN    = longint'(1) << (ANGLE_BITS - 2);
   localparam longint UNIT        = longint'(1) << FRACTION_BITS;

   localparam logic [FIELD_W-1:0] UNIT_POS = 16'h4000;
   localparam logic [FIELD_W-1:0] UNIT_NEG = 16'hC000;

   // index 0 is elem_00, index 8 is elem_22
   typedef logic [0:8][FIELD_W-1:0] rot_matrix_type;

   typedef struct {
      logic [FIELD_W-1:0] roll;
      logic [FIELD_W-1:0] pitch;
      logic [FIELD_W-1:0] yaw;
      bit                 known;
      rot_matrix_type     want;
   } angle_row_type;

   logic           clock;
   logic           reset;
   bit             steady_run;
   int unsigned    mismatch_count;
   int unsigned    matrices_seen;
   longint         sine_lut [0:SINE_TABLE_DEPTH];
   rot_matrix_type pending_matrices [$];

   string elem_label [0:8] = '{"elem_00", "elem_01", "elem_02", "elem_10", "elem_11",
                               "elem_12", "elem_20", "elem_21", "elem_22"};

   angle_row_type directed_rows [0:19] = '{
      '{16'h0000, 16'h0000, 16'h0000, 1'b1,
        '{UNIT_POS, 16'h0, 16'h0, 16'h0, UNIT_POS, 16'h0, 16'h0, 16'h0, UNIT_POS}},
      '{16'h0000, 16'h4000, 16'h0000, 1'b1,
        '{16'h0, 16'h0, UNIT_POS, 16'h0, UNIT_POS, 16'h0, UNIT_NEG, 16'h0, 16'h0}},
      '{16'h0000, 16'h0000, 16'h8000, 1'b1,
        '{UNIT_NEG, 16'h0, 16'h0, 16'h0, UNIT_NEG, 16'h0, 16'h0, 16'h0, UNIT_POS}},
      '{16'h4000, 16'h0000, 16'h0000, 1'b1,
        '{UNIT_POS, 16'h0, 16'h0, 16'h0, 16'h0, UNIT_NEG, 16'h0, UNIT_POS, 16'h0}},
      '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, '0},
      '{16'hC000, 16'h0000, 16'h0000, 1'b0, '0},
      '{16'h8000, 16'h0000, 16'h0000, 1'b0, '0},
      '{16'h0000, 16'h8000, 16'h0000, 1'b0, '0},
      '{16'h0000, 16'hC000, 16'h0000, 1'b0, '0},
      '{16'h0000, 16'h0000, 16'h4000, 1'b0, '0},
      '{16'h0000, 16'h0000, 16'hC000, 1'b0, '0},
      '{16'h3FFF, 16'h3FFF, 16'h3FFF, 1'b0, '0},
      '{16'h4001, 16'hBFFF, 16'h7FFF, 1'b0, '0},
      '{16'h0001, 16'h8001, 16'hC001, 1'b0, '0},
      '{16'h2000, 16'h2000, 16'h2000, 1'b0, '0},
      '{16'h6000, 16'hA000, 16'hE000, 1'b0, '0},
      '{16'h00FF, 16'h0040, 16'h3FC0, 1'b0, '0},
      '{16'h1234, 16'hABCD, 16'h5A5A, 1'b0, '0},
      '{16'hAAAA, 16'h5555, 16'hFFFF, 1'b0, '0},
      '{16'h3FC1, 16'h7F3F, 16'hEDCB, 1'b0, '0}
   };

   e2r_req_if req_bus ();
   e2r_rsp_if rsp_bus ();

   euler_to_rotation_matrix u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // floor(a * b / 2^60)
   function automatic logic [63:0] q60_product(logic [63:0] a, logic [63:0] b);
      logic [127:0] wide;
      wide = {64'd0, a} * {64'd0, b};
      return wide[123:60];
   endfunction

   function automatic logic [63:0] taylor_sine(logic [63:0] x);
      logic [63:0] x_sq;
      logic [63:0] term;
      logic [63:0] acc;
      x_sq = q60_product(x, x);
      term = x;
      acc  = x;
      for (int k = 1; k <= 16; k++) begin
         term = q60_product(term, x_sq) / 64'((2 * k) * (2 * k + 1));
         if (term == 0) break;
         acc = (k % 2 == 1) ? acc - term : acc + term;
      end
      return acc;
   endfunction

   // interpolated sine of r in [0, quarter turn]
   function automatic longint wave_quarter(longint r);
      longint pos;
      longint idx;
      longint rem;
      pos = r * SINE_TABLE_DEPTH;
      idx = pos >>> (ANGLE_BITS - 2);
      rem = pos & (QTR_TURN - 1);
      if (idx >= SINE_TABLE_DEPTH) return sine_lut[SINE_TABLE_DEPTH];
      return sine_lut[idx] + (((sine_lut[idx + 1] - sine_lut[idx]) * rem + QTR_TURN / 2)
                              >>> (ANGLE_BITS - 2));
   endfunction

   function automatic longint wave_sine(angle_type a);
      longint quadrant;
      longint r;
      longint v;
      quadrant = longint'(a) >>> (ANGLE_BITS - 2);
      r        = longint'(a) & (QTR_TURN - 1);
      v        = quadrant[0] ? wave_quarter(QTR_TURN - r) : wave_quarter(r);
      return quadrant[1] ? -v : v;
   endfunction

   function automatic longint round_q(longint v);
      return (v + (longint'(1) <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS;
   endfunction

   function automatic logic [FIELD_W-1:0] to_elem(longint v);
      if (v > UNIT) v = UNIT;
      if (v < -UNIT) v = -UNIT;
      return FIELD_W'(v);
   endfunction

   function automatic rot_matrix_type rotation_of(logic [FIELD_W-1:0] roll,
                                                  logic [FIELD_W-1:0] pitch,
                                                  logic [FIELD_W-1:0] yaw);
      angle_type      ra;
      angle_type      pa;
      angle_type      ya;
      longint         sr, cr, sp, cp, sy, cy, spcy, spsy;
      rot_matrix_type m;
      ra   = angle_type'(roll);
      pa   = angle_type'(pitch);
      ya   = angle_type'(yaw);
      sr   = wave_sine(ra);
      cr   = wave_sine(angle_type'(ra + QTR_TURN));
      sp   = wave_sine(pa);
      cp   = wave_sine(angle_type'(pa + QTR_TURN));
      sy   = wave_sine(ya);
      cy   = wave_sine(angle_type'(ya + QTR_TURN));
      spcy = round_q(sp * cy);
      spsy = round_q(sp * sy);
      m[0] = to_elem(round_q(cp * cy));
      m[1] = to_elem(round_q(sr * spcy - cr * sy));
      m[2] = to_elem(round_q(sr * sy + cr * spcy));
      m[3] = to_elem(round_q(cp * sy));
      m[4] = to_elem(round_q(cr * cy + sr * spsy));
      m[5] = to_elem(round_q(cr * spsy - sr * cy));
      m[6] = to_elem(-sp);
      m[7] = to_elem(round_q(sr * cp));
      m[8] = to_elem(round_q(cr * cp));
      return m;
   endfunction

   // mostly uniform, sometimes within 4 units of a quadrant boundary
   function automatic logic [FIELD_W-1:0] pick_angle();
      if ($urandom_range(99) < 30)
         return FIELD_W'(($urandom_range(3) << (ANGLE_BITS - 2)) + $urandom_range(8) - 4);
      return FIELD_W'($urandom_range(16'hFFFF));
   endfunction

   task automatic offer_angles(logic [FIELD_W-1:0] roll, logic [FIELD_W-1:0] pitch,
                               logic [FIELD_W-1:0] yaw, rot_matrix_type want);
      while (!steady_run && $urandom_range(99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.roll_angle  <= roll;
      req_bus.pitch_angle <= pitch;
      req_bus.yaw_angle   <= yaw;
      do @(posedge clock); while (!req_bus.ready);
      pending_matrices.push_back(want);
   endtask

   initial begin : stimulus
      logic [63:0]        step;
      logic [63:0]        rest;
      logic [63:0]        x;
      logic [FIELD_W-1:0] roll, pitch, yaw;
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.roll_angle  <= '0;
      req_bus.pitch_angle <= '0;
      req_bus.yaw_angle   <= '0;
      steady_run     = 1'b0;
      mismatch_count = 0;
      step = HALF_PI_Q60 / SINE_TABLE_DEPTH;
      rest = HALF_PI_Q60 % SINE_TABLE_DEPTH;
      for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
         x = step * 64'(i) + (rest * 64'(i)) / SINE_TABLE_DEPTH;
         sine_lut[i] = longint'((taylor_sine(x) + (64'd1 << (59 - FRACTION_BITS)))
                                >> (60 - FRACTION_BITS));
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         offer_angles(directed_rows[i].roll, directed_rows[i].pitch, directed_rows[i].yaw,
                      directed_rows[i].known ? directed_rows[i].want :
                      rotation_of(directed_rows[i].roll, directed_rows[i].pitch,
                                  directed_rows[i].yaw));
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         steady_run = (n >= 400 && n < 600);
         if (n == 900) begin
            // drain the pipeline completely before going on
            req_bus.valid <= 1'b0;
            do @(posedge clock); while (pending_matrices.size() != 0);
         end
         roll  = pick_angle();
         pitch = pick_angle();
         yaw   = pick_angle();
         offer_angles(roll, pitch, yaw, rotation_of(roll, pitch, yaw));
      end
      req_bus.valid <= 1'b0;

      while (pending_matrices.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && pending_matrices.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin : result_side
      int             hold_left;
      bit             held_once;
      rot_matrix_type got;
      rot_matrix_type want;
      hold_left     = 0;
      held_once     = 1'b0;
      matrices_seen = 0;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (!held_once && matrices_seen >= 300) begin
            held_once = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            // stall the output so the pipeline backs up into the input
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_bus.ready <= steady_run || ($urandom_range(99) >= IDLE_PERCENT);
         end
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready) begin
            matrices_seen++;
            got = {rsp_bus.elem_00, rsp_bus.elem_01, rsp_bus.elem_02,
                   rsp_bus.elem_10, rsp_bus.elem_11, rsp_bus.elem_12,
                   rsp_bus.elem_20, rsp_bus.elem_21, rsp_bus.elem_22};
            if (pending_matrices.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("unexpected item on output at %0t", $realtime);
            end else begin
               want = pending_matrices.pop_front();
               for (int e = 0; e < 9; e++) begin
                  if (got[e] !== want[e]) begin
                     mismatch_count++;
                     if (mismatch_count <= MAX_REPORTS)
                        $display("%s mismatch at %0t: expected %0d, got %0d", elem_label[e],
                                 $realtime, $signed(want[e]), $signed(got[e]));
                  end
               end
            end
         end
      end
   end

   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Some tests failed");
      $finish;
   end

endmodule
